// File: rtl/bhs_pkg.sv
`timescale 1ns / 1ps
package bhs_pkg;

    // Default sizes of the grid storage and of the coordinate fraction
    localparam int MAX_WIDTH_DEF     = 512;
    localparam int MAX_HEIGHT_DEF    = 512;
    localparam int FRACTION_BITS_DEF = 8;

    // Fixed field widths of the channels
    localparam int CELL_W      = 9;
    localparam int HEIGHT_W    = 16;
    localparam int COORD_W     = 18;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 10;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Size registers come out of reset at 512 cells
    localparam logic [CFG_DATA_W-1:0] CFG_SIZE_RESET = 10'd512;

    // Command codes
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_GRID_HEIGHT = 1'b1;

    // Bits of a half index (cell index over two) for one grid dimension
    function automatic int half_bits(int max_dim);
        int cw;
        cw = $clog2(max_dim);
        return (cw > 1) ? cw - 1 : 1;
    endfunction

    // Bits of one queued command word
    function automatic int cmd_bits(int cb, int rb, int fb);
        return 1 + 2 * cb + 2 * rb + 2 + HEIGHT_W + 2 * fb;
    endfunction

endpackage

// File: rtl/bhs_front.sv
`timescale 1ns / 1ps
module bhs_front
    import bhs_pkg::*;
#(
    parameter int MAX_WIDTH     = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT    = MAX_HEIGHT_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic                      i_command,
    input  logic [CELL_W-1:0]         i_cell_column,
    input  logic [CELL_W-1:0]         i_cell_row,
    input  logic [HEIGHT_W-1:0]       i_height_value,
    input  logic signed [COORD_W-1:0] i_sample_x,
    input  logic signed [COORD_W-1:0] i_sample_y,
    input  logic                      i_cfg_we,
    input  logic [CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data,
    output logic                      o_push,
    output logic [cmd_bits(half_bits(MAX_WIDTH), half_bits(MAX_HEIGHT), FRACTION_BITS)-1:0] o_cmd,
    input  logic                      i_q_full
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int CB  = half_bits(MAX_WIDTH);
    localparam int RB  = half_bits(MAX_HEIGHT);
    localparam int FB  = FRACTION_BITS;
    localparam int IPW = COORD_W - 1 - FB;

    typedef struct packed {
        logic                sample;
        logic [CB-1:0]       col_even;
        logic [CB-1:0]       col_odd;
        logic [RB-1:0]       row_even;
        logic [RB-1:0]       row_odd;
        logic                col_par;
        logic                row_par;
        logic [HEIGHT_W-1:0] height;
        logic [FB-1:0]       tx;
        logic [FB-1:0]       ty;
    } t_cmd;

    // Last usable index for a size register value: zero acts as one, large values clip
    function automatic int size_last(logic [CFG_DATA_W-1:0] v, int limit);
        if (v == '0) begin
            return 0;
        end else if (int'(v) > limit) begin
            return limit - 1;
        end else begin
            return int'(v) - 1;
        end
    endfunction

    logic [CW-1:0]  r_w_last;
    logic [RW-1:0]  r_h_last;
    logic           r_valid;
    t_cmd           r_cmd;
    t_cmd           n_cmd;
    logic           n_keep;
    logic           f_adv;

    logic [IPW-1:0] x_int;
    logic [IPW-1:0] y_int;
    logic           x_sat;
    logic           y_sat;
    logic [CW-1:0]  x0;
    logic [RW-1:0]  y0;
    logic [FB-1:0]  tx;
    logic [FB-1:0]  ty;
    logic           wr_ok;

    // Hold the size registers as last valid indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_last <= CW'(size_last(CFG_SIZE_RESET, MAX_WIDTH));
            r_h_last <= RW'(size_last(CFG_SIZE_RESET, MAX_HEIGHT));
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_GRID_WIDTH:  r_w_last <= CW'(size_last(i_cfg_data, MAX_WIDTH));
                REG_GRID_HEIGHT: r_h_last <= RW'(size_last(i_cfg_data, MAX_HEIGHT));
                default: ;
            endcase
        end
    end

    // Clamp the column coordinate: negative goes to zero, at or past the last
    // column goes to the last column with no fraction
    assign x_int = i_sample_x[COORD_W-2:FB];
    assign x_sat = 32'(x_int) >= 32'(r_w_last);

    always_comb begin
        if (i_sample_x[COORD_W-1]) begin
            x0 = '0;
            tx = '0;
        end else if (x_sat) begin
            x0 = r_w_last;
            tx = '0;
        end else begin
            x0 = CW'(x_int);
            tx = i_sample_x[FB-1:0];
        end
    end

    // Clamp the row coordinate the same way
    assign y_int = i_sample_y[COORD_W-2:FB];
    assign y_sat = 32'(y_int) >= 32'(r_h_last);

    always_comb begin
        if (i_sample_y[COORD_W-1]) begin
            y0 = '0;
            ty = '0;
        end else if (y_sat) begin
            y0 = r_h_last;
            ty = '0;
        end else begin
            y0 = RW'(y_int);
            ty = i_sample_y[FB-1:0];
        end
    end

    // Drop writes that fall outside the storage
    assign wr_ok = (32'(i_cell_column) < MAX_WIDTH) && (32'(i_cell_row) < MAX_HEIGHT);

    // Split cells over the four parity banks: the even and odd neighbor of
    // each dimension get their own half index
    always_comb begin
        n_cmd = '0;
        if (i_command == CMD_SAMPLE) begin
            n_cmd.sample   = 1'b1;
            n_cmd.col_par  = x0[0];
            n_cmd.col_odd  = CB'(x0 >> 1);
            n_cmd.col_even = CB'(x0 >> 1) + CB'(x0[0]);
            n_cmd.row_par  = y0[0];
            n_cmd.row_odd  = RB'(y0 >> 1);
            n_cmd.row_even = RB'(y0 >> 1) + RB'(y0[0]);
            n_cmd.tx       = tx;
            n_cmd.ty       = ty;
        end else begin
            n_cmd.sample   = 1'b0;
            n_cmd.col_par  = i_cell_column[0];
            n_cmd.col_odd  = CB'(i_cell_column >> 1);
            n_cmd.col_even = CB'(i_cell_column >> 1);
            n_cmd.row_par  = i_cell_row[0];
            n_cmd.row_odd  = RB'(i_cell_row >> 1);
            n_cmd.row_even = RB'(i_cell_row >> 1);
            n_cmd.height   = i_height_value;
        end
        n_keep = (i_command == CMD_SAMPLE) || wr_ok;
    end

    // Register the classified word until the queue takes it
    assign f_adv      = !r_valid || !i_q_full;
    assign o_in_stall = !f_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (f_adv) begin
            r_valid <= i_in_valid && n_keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (f_adv) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_push = r_valid && !i_q_full;
    assign o_cmd  = r_cmd;

endmodule

// File: rtl/bhs_queue.sv
`timescale 1ns / 1ps
module bhs_queue
    import bhs_pkg::*;
#(
    parameter int WIDTH = 1,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_data [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CNTW-1:0]  r_count;

    function automatic logic [PW-1:0] ptr_next(logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_next(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_next(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNTW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CNTW'(1);
            end
        end
    end

    // Store pushed words
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wr_ptr] <= i_data;
        end
    end

    assign o_full  = r_count == CNTW'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_data[r_rd_ptr];

endmodule

// File: rtl/bhs_back.sv
`timescale 1ns / 1ps
module bhs_back
    import bhs_pkg::*;
#(
    parameter int MAX_WIDTH     = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT    = MAX_HEIGHT_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  logic [cmd_bits(half_bits(MAX_WIDTH), half_bits(MAX_HEIGHT), FRACTION_BITS)-1:0] i_cmd,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [HEIGHT_W-1:0] o_sampled_height
);

    localparam int CB    = half_bits(MAX_WIDTH);
    localparam int RB    = half_bits(MAX_HEIGHT);
    localparam int FB    = FRACTION_BITS;
    localparam int ABITS = RB + CB;
    localparam int DEPTH = 1 << ABITS;
    localparam int WW    = FB + 1;
    localparam int AW    = HEIGHT_W + FB + 1;
    localparam int SW    = HEIGHT_W + 2 * FB + 1;

    typedef struct packed {
        logic                sample;
        logic [CB-1:0]       col_even;
        logic [CB-1:0]       col_odd;
        logic [RB-1:0]       row_even;
        logic [RB-1:0]       row_odd;
        logic                col_par;
        logic                row_par;
        logic [HEIGHT_W-1:0] height;
        logic [FB-1:0]       tx;
        logic [FB-1:0]       ty;
    } t_cmd;

    t_cmd                q_cmd;
    logic                adv;
    logic [HEIGHT_W-1:0] rd_data [4];

    logic                r_s1_valid;
    logic                r_s1_xp;
    logic                r_s1_yp;
    logic [FB-1:0]       r_s1_tx;
    logic [FB-1:0]       r_s1_ty;

    logic                r_s2_valid;
    logic [AW-1:0]       r_s2_a;
    logic [AW-1:0]       r_s2_b;
    logic [FB-1:0]       r_s2_ty;

    logic                r_out_valid;
    logic [HEIGHT_W-1:0] r_out_height;

    logic [HEIGHT_W-1:0] even_lo;
    logic [HEIGHT_W-1:0] even_hi;
    logic [HEIGHT_W-1:0] odd_lo;
    logic [HEIGHT_W-1:0] odd_hi;
    logic [HEIGHT_W-1:0] h00;
    logic [HEIGHT_W-1:0] h10;
    logic [HEIGHT_W-1:0] h01;
    logic [HEIGHT_W-1:0] h11;
    logic [WW-1:0]       wx0;
    logic [WW-1:0]       wx1;
    logic [WW-1:0]       wy0;
    logic [WW-1:0]       wy1;
    logic [AW-1:0]       n_a;
    logic [AW-1:0]       n_b;
    logic [SW-1:0]       n_sum;

    assign q_cmd = i_cmd;

    // Freeze the whole back pipeline while the result waits to be taken
    assign adv   = !r_out_valid || !i_out_stall;
    assign o_pop = adv && i_q_valid;

    // Four grid banks split by row and column parity; bank index is {row, column}
    for (genvar k = 0; k < 4; k++) begin : g_bank
        localparam bit RP = (k / 2) == 1;
        localparam bit CP = (k % 2) == 1;

        logic [HEIGHT_W-1:0] r_mem [DEPTH];
        logic [HEIGHT_W-1:0] r_rd;
        logic [ABITS-1:0]    addr;
        logic                we;

        assign addr = {(RP ? q_cmd.row_odd : q_cmd.row_even),
                       (CP ? q_cmd.col_odd : q_cmd.col_even)};
        assign we   = adv && i_q_valid && !q_cmd.sample
                      && (q_cmd.row_par == RP) && (q_cmd.col_par == CP);

        always_ff @(posedge i_clk) begin
            if (we) begin
                r_mem[addr] <= q_cmd.height;
            end
            if (adv) begin
                r_rd <= r_mem[addr];
            end
        end

        assign rd_data[k] = r_rd;
    end

    // Carry the sample flags alongside the bank reads
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= i_q_valid && q_cmd.sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_xp <= q_cmd.col_par;
            r_s1_yp <= q_cmd.row_par;
            r_s1_tx <= q_cmd.tx;
            r_s1_ty <= q_cmd.ty;
        end
    end

    // Route banks to the four neighbors; a neighbor with zero weight takes
    // the near cell so that an unused far cell never reaches the sum
    always_comb begin
        even_lo = r_s1_xp ? rd_data[1] : rd_data[0];
        even_hi = r_s1_xp ? rd_data[0] : rd_data[1];
        odd_lo  = r_s1_xp ? rd_data[3] : rd_data[2];
        odd_hi  = r_s1_xp ? rd_data[2] : rd_data[3];

        h00 = r_s1_yp ? odd_lo : even_lo;
        h10 = (r_s1_tx == '0) ? h00 : (r_s1_yp ? odd_hi : even_hi);
        h01 = (r_s1_ty == '0) ? h00 : (r_s1_yp ? even_lo : odd_lo);
        if (r_s1_tx == '0) begin
            h11 = h01;
        end else if (r_s1_ty == '0) begin
            h11 = h10;
        end else begin
            h11 = r_s1_yp ? even_hi : odd_hi;
        end

        wx1 = WW'(r_s1_tx);
        wx0 = (WW'(1) << FB) - WW'(r_s1_tx);
        n_a = AW'(h00) * AW'(wx0) + AW'(h10) * AW'(wx1);
        n_b = AW'(h01) * AW'(wx0) + AW'(h11) * AW'(wx1);
    end

    // Register the two row blends
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (adv) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s2_a  <= n_a;
            r_s2_b  <= n_b;
            r_s2_ty <= r_s1_ty;
        end
    end

    // Blend the rows and drop the fraction bits
    always_comb begin
        wy1   = WW'(r_s2_ty);
        wy0   = (WW'(1) << FB) - WW'(r_s2_ty);
        n_sum = SW'(r_s2_a) * SW'(wy0) + SW'(r_s2_b) * SW'(wy1);
    end

    // Hold the result until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_height <= n_sum[2*FB+HEIGHT_W-1:2*FB];
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_sampled_height = r_out_height;

endmodule

// File: rtl/bilinear_height_sampler_core.sv
`timescale 1ns / 1ps
// Bilinear height sampler with edge clamping over a stored height grid.
// Input channel (i_in_valid / o_in_stall): each word is either a height write
// (column, row, value) or a sample request (signed x, y with fraction bits).
// Output channel (o_out_valid / i_out_stall): one sampled height per sample
// request, in request order; writes give no output word.
// Configuration: i_cfg_we writes grid_width (index 0) or grid_height (index 1)
// from i_cfg_data; write only while no request is in flight.
// Throughput: one word per cycle while the receiver does not stall. Each sample reads
// its four neighbors together from four grid banks split by row and column parity, one read port each.
// An accepted sample passes the front register, queue, bank read, row blend and output register to o_out_valid.
// When the receiver stalls, the blend pipeline freezes with the result held;
// a four-word queue keeps taking input, then o_in_stall rises.
// Reset (synchronous, active low) empties the pipeline and queue and sets both
// sizes to 512. The grid is not cleared: cells must be written before read.
module bilinear_height_sampler_core
    import bhs_pkg::*;
#(
    parameter int MAX_WIDTH     = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT    = MAX_HEIGHT_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic                      i_command,
    input  logic [CELL_W-1:0]         i_cell_column,
    input  logic [CELL_W-1:0]         i_cell_row,
    input  logic [HEIGHT_W-1:0]       i_height_value,
    input  logic signed [COORD_W-1:0] i_sample_x,
    input  logic signed [COORD_W-1:0] i_sample_y,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [HEIGHT_W-1:0]       o_sampled_height,
    input  logic                      i_cfg_we,
    input  logic [CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int CMD_W = cmd_bits(half_bits(MAX_WIDTH), half_bits(MAX_HEIGHT),
                                    FRACTION_BITS);

    logic             push;
    logic             pop;
    logic             q_full;
    logic             q_valid;
    logic [CMD_W-1:0] f_cmd;
    logic [CMD_W-1:0] q_cmd;

    // Accept and classify words
    bhs_front #(
        .MAX_WIDTH     (MAX_WIDTH),
        .MAX_HEIGHT    (MAX_HEIGHT),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_command      (i_command),
        .i_cell_column  (i_cell_column),
        .i_cell_row     (i_cell_row),
        .i_height_value (i_height_value),
        .i_sample_x     (i_sample_x),
        .i_sample_y     (i_sample_y),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_push         (push),
        .o_cmd          (f_cmd),
        .i_q_full       (q_full)
    );

    // Decouple front from back
    bhs_queue #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (f_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_cmd)
    );

    // Store heights and blend samples
    bhs_back #(
        .MAX_WIDTH     (MAX_WIDTH),
        .MAX_HEIGHT    (MAX_HEIGHT),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (q_valid),
        .i_cmd            (q_cmd),
        .o_pop            (pop),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_sampled_height (o_sampled_height)
    );

endmodule

// File: tb/sv/height_sample_monitor.sv
`timescale 1ns / 1ps
module height_sample_monitor
    import bhs_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_in_stall,
    input  logic                      i_command,
    input  logic [CELL_W-1:0]         i_cell_column,
    input  logic [CELL_W-1:0]         i_cell_row,
    input  logic [HEIGHT_W-1:0]       i_height_value,
    input  logic signed [COORD_W-1:0] i_sample_x,
    input  logic signed [COORD_W-1:0] i_sample_y,
    input  logic                      i_out_valid,
    input  logic                      i_out_stall,
    input  logic [HEIGHT_W-1:0]       i_sampled_height,
    input  logic                      i_cfg_we,
    input  logic [CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data,
    output int                        o_pending_count,
    output int                        o_mismatch_count
);

    localparam int FB        = FRACTION_BITS_DEF;
    localparam int MAX_SHOWN = 100;

    // Shadow copy of the grid and of the size registers
    logic [HEIGHT_W-1:0]   grid_heights [0:MAX_WIDTH_DEF*MAX_HEIGHT_DEF-1];
    logic [CFG_DATA_W-1:0] width_reg  = CFG_SIZE_RESET;
    logic [CFG_DATA_W-1:0] height_reg = CFG_SIZE_RESET;

    // Heights still owed by the block, oldest first
    logic [HEIGHT_W-1:0] expected_heights [$];
    logic [HEIGHT_W-1:0] oldest_height;
    int                  mismatches = 0;

    initial begin
        o_pending_count  = 0;
        o_mismatch_count = 0;
    end

    // Zero acts as one cell, oversize acts as the full storage
    function automatic int eff_size(input int reg_val, input int limit);
        if (reg_val == 0) return 1;
        if (reg_val > limit) return limit;
        return reg_val;
    endfunction

    // Saturate one coordinate to [0, size-1] in fraction units
    function automatic int clamp_axis(input logic signed [COORD_W-1:0] c, input int size);
        int top_pos;
        int pos;
        top_pos = (size - 1) << FB;
        pos     = c;
        if (pos < 0) return 0;
        if (pos > top_pos) return top_pos;
        return pos;
    endfunction

    // Fetch four neighbors with edge clamp and blend them with weights in units of 1/256
    function automatic logic [HEIGHT_W-1:0] blend_height(
        input logic signed [COORD_W-1:0] sx,
        input logic signed [COORD_W-1:0] sy
    );
        int                  w, h, xc, yc, x0, x1, y0, y1;
        longint unsigned     one, tx, ty, a, b;
        logic [63:0]         mix;
        w   = eff_size(int'(width_reg), MAX_WIDTH_DEF);
        h   = eff_size(int'(height_reg), MAX_HEIGHT_DEF);
        xc  = clamp_axis(sx, w);
        yc  = clamp_axis(sy, h);
        one = 64'd1 << FB;
        x0  = xc >> FB;
        y0  = yc >> FB;
        tx  = xc & ((1 << FB) - 1);
        ty  = yc & ((1 << FB) - 1);
        x1  = (x0 + 1 < w) ? x0 + 1 : w - 1;
        y1  = (y0 + 1 < h) ? y0 + 1 : h - 1;
        a   = grid_heights[y0*MAX_WIDTH_DEF + x0] * (one - tx)
            + grid_heights[y0*MAX_WIDTH_DEF + x1] * tx;
        b   = grid_heights[y1*MAX_WIDTH_DEF + x0] * (one - tx)
            + grid_heights[y1*MAX_WIDTH_DEF + x1] * tx;
        mix = (a * (one - ty) + b * ty) >> (2 * FB);
        return mix[HEIGHT_W-1:0];
    endfunction

    // Print one line per mismatch (capped) and count every one
    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_SHOWN) $display("mismatch: %s", msg);
    endtask

    // Track config, stored heights and owed samples; compare each output word
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_heights.delete();
            width_reg  = CFG_SIZE_RESET;
            height_reg = CFG_SIZE_RESET;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_GRID_WIDTH:  width_reg  = i_cfg_data;
                    REG_GRID_HEIGHT: height_reg = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_command == CMD_WRITE) begin
                    if (int'(i_cell_column) < MAX_WIDTH_DEF && int'(i_cell_row) < MAX_HEIGHT_DEF)
                        grid_heights[int'(i_cell_row)*MAX_WIDTH_DEF + int'(i_cell_column)] =
                            i_height_value;
                end else begin
                    expected_heights.push_back(blend_height(i_sample_x, i_sample_y));
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_heights.size() == 0) begin
                    report_mismatch($sformatf("height %0d with no sample waiting",
                                              i_sampled_height));
                end else begin
                    oldest_height = expected_heights.pop_front();
                    if (i_sampled_height !== oldest_height)
                        report_mismatch($sformatf("sampled_height %0d, want %0d",
                                                  i_sampled_height, oldest_height));
                end
            end
        end
        o_pending_count  <= expected_heights.size();
        o_mismatch_count <= mismatches;
    end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;
    import bhs_pkg::*;

    localparam int FB            = FRACTION_BITS_DEF;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 10;
    localparam int TAIL_CYCLES   = 20;
    localparam int PHASE_WORDS   = 70;
    localparam int LONG_HOLD     = 400;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_in_valid;
    logic                      o_in_stall;
    logic                      i_command;
    logic [CELL_W-1:0]         i_cell_column;
    logic [CELL_W-1:0]         i_cell_row;
    logic [HEIGHT_W-1:0]       i_height_value;
    logic signed [COORD_W-1:0] i_sample_x;
    logic signed [COORD_W-1:0] i_sample_y;
    logic                      o_out_valid;
    logic                      i_out_stall;
    logic [HEIGHT_W-1:0]       o_sampled_height;
    logic                      i_cfg_we;
    logic [CFG_INDEX_W-1:0]    i_cfg_index;
    logic [CFG_DATA_W-1:0]     i_cfg_data;

    int pending_count;
    int mismatch_count;
    int cycle_count;
    bit idle_on;
    bit hold_request;
    int grid_w;
    int grid_h;

    // Cells written since reset; samples only touch these
    bit cell_written [0:MAX_WIDTH_DEF*MAX_HEIGHT_DEF-1];

    bilinear_height_sampler_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_command        (i_command),
        .i_cell_column    (i_cell_column),
        .i_cell_row       (i_cell_row),
        .i_height_value   (i_height_value),
        .i_sample_x       (i_sample_x),
        .i_sample_y       (i_sample_y),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_sampled_height (o_sampled_height),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    height_sample_monitor monitor (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_command        (i_command),
        .i_cell_column    (i_cell_column),
        .i_cell_row       (i_cell_row),
        .i_height_value   (i_height_value),
        .i_sample_x       (i_sample_x),
        .i_sample_y       (i_sample_y),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_sampled_height (o_sampled_height),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_pending_count  (pending_count),
        .o_mismatch_count (mismatch_count)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Watchdog: end the run if it hangs
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("status: fail");
        $finish;
    end

    // Receiver: random stall bursts, plus one long hold on request
    initial begin
        int hold_left;
        int gap_left;
        i_out_stall <= 1'b0;
        hold_left = 0;
        gap_left  = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (gap_left > 0) begin
                gap_left--;
                i_out_stall <= 1'b1;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                gap_left = $urandom_range(0, 8);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    function automatic int eff_size(input int reg_val, input int limit);
        if (reg_val == 0) return 1;
        if (reg_val > limit) return limit;
        return reg_val;
    endfunction

    // Near and far cell of one axis after the edge clamp
    task automatic axis_cells(input logic signed [COORD_W-1:0] c, input int size,
                              output int c0, output int c1);
        int top_pos;
        int pos;
        top_pos = (size - 1) << FB;
        pos     = c;
        if (pos < 0) pos = 0;
        else if (pos > top_pos) pos = top_pos;
        c0 = pos >> FB;
        c1 = (c0 + 1 < size) ? c0 + 1 : size - 1;
    endtask

    function automatic logic [HEIGHT_W-1:0] rand_height();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return r[HEIGHT_W-1:0];
        endcase
    endfunction

    // Mostly inside the grid in use, sometimes anywhere in storage
    function automatic logic [CELL_W-1:0] rand_cell(input int size);
        int v;
        if ($urandom_range(0, 99) < 80) v = $urandom_range(0, size - 1);
        else v = $urandom_range(0, MAX_WIDTH_DEF - 1);
        return v[CELL_W-1:0];
    endfunction

    // Mostly near the grid, sometimes extreme or fully random
    function automatic logic signed [COORD_W-1:0] rand_coord(input int size);
        int          v;
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 9))
            0: v = int'(r);
            1: begin
                case ($urandom_range(0, 3))
                    0:       v = -131072;
                    1:       v = 131071;
                    2:       v = -1;
                    default: v = (size - 1) << FB;
                endcase
            end
            default: v = int'($urandom_range(0, (size << FB) + 1023)) - 512;
        endcase
        return v[COORD_W-1:0];
    endfunction

    // Offer one word, with an optional idle gap first; return at acceptance
    task automatic push_word(input logic cmd,
                             input logic [CELL_W-1:0] col, input logic [CELL_W-1:0] row,
                             input logic [HEIGHT_W-1:0] hv,
                             input logic signed [COORD_W-1:0] sx,
                             input logic signed [COORD_W-1:0] sy);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_command      <= cmd;
        i_cell_column  <= col;
        i_cell_row     <= row;
        i_height_value <= hv;
        i_sample_x     <= sx;
        i_sample_y     <= sy;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic send_write(input logic [CELL_W-1:0] col, input logic [CELL_W-1:0] row,
                              input logic [HEIGHT_W-1:0] hv);
        logic [31:0] r1;
        logic [31:0] r2;
        r1 = $urandom;
        r2 = $urandom;
        push_word(CMD_WRITE, col, row, hv, r1[COORD_W-1:0], r2[COORD_W-1:0]);
        cell_written[int'(row)*MAX_WIDTH_DEF + int'(col)] = 1'b1;
    endtask

    task automatic ensure_written(input int col, input int row);
        if (!cell_written[row*MAX_WIDTH_DEF + col])
            send_write(col[CELL_W-1:0], row[CELL_W-1:0], rand_height());
    endtask

    // Fill any unwritten neighbor first, then request the sample
    task automatic send_sample(input logic signed [COORD_W-1:0] sx,
                               input logic signed [COORD_W-1:0] sy);
        int          x0, x1, y0, y1;
        logic [31:0] r;
        axis_cells(sx, grid_w, x0, x1);
        axis_cells(sy, grid_h, y0, y1);
        ensure_written(x0, y0);
        ensure_written(x1, y0);
        ensure_written(x0, y1);
        ensure_written(x1, y1);
        r = $urandom;
        push_word(CMD_SAMPLE, r[8:0], r[17:9], r[31:16], sx, sy);
    endtask

    task automatic write_grid_size(input int w_raw, input int h_raw);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_GRID_WIDTH;
        i_cfg_data  <= w_raw[CFG_DATA_W-1:0];
        @(posedge i_clk);
        i_cfg_index <= REG_GRID_HEIGHT;
        i_cfg_data  <= h_raw[CFG_DATA_W-1:0];
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        grid_w = eff_size(w_raw, MAX_WIDTH_DEF);
        grid_h = eff_size(h_raw, MAX_HEIGHT_DEF);
    endtask

    // Drain, resize the grid, then run a block of random words
    task automatic run_phase(input int w_raw, input int h_raw, input bit idle,
                             input bit long_hold);
        int k;
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        write_grid_size(w_raw, h_raw);
        idle_on = idle;
        if (long_hold) hold_request = 1'b1;
        for (k = 0; k < PHASE_WORDS; k++) begin
            if ($urandom_range(0, 99) < 35)
                send_write(rand_cell(grid_w), rand_cell(grid_h), rand_height());
            else
                send_sample(rand_coord(grid_w), rand_coord(grid_h));
        end
    endtask

    // Stimulus and verdict
    initial begin
        int k;
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_command      <= CMD_WRITE;
        i_cell_column  <= '0;
        i_cell_row     <= '0;
        i_height_value <= '0;
        i_sample_x     <= '0;
        i_sample_y     <= '0;
        i_cfg_we       <= 1'b0;
        i_cfg_index    <= REG_GRID_WIDTH;
        i_cfg_data     <= '0;
        idle_on      = 1'b1;
        hold_request = 1'b0;
        grid_w       = MAX_WIDTH_DEF;
        grid_h       = MAX_HEIGHT_DEF;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extreme heights at both far corners, samples at the edges
        send_write(9'd0,   9'd0,   16'd0);
        send_write(9'd1,   9'd0,   16'hFFFF);
        send_write(9'd0,   9'd1,   16'hFFFF);
        send_write(9'd1,   9'd1,   16'd0);
        send_write(9'd511, 9'd511, 16'hFFFF);
        send_write(9'd510, 9'd511, 16'd0);
        send_write(9'd511, 9'd510, 16'd0);
        send_write(9'd510, 9'd510, 16'hFFFF);
        send_sample(18'sd0, 18'sd0);
        send_sample(18'sd128, 18'sd64);
        send_sample(18'sd255, 18'sd255);
        send_sample(-18'sd131072, -18'sd131072);
        send_sample(18'sd131071, 18'sd131071);
        send_sample(-18'sd1, 18'sd131071);
        send_sample(18'sd131071, -18'sd1);
        send_sample(18'sd130815, 18'sd130815);
        send_sample(18'sd130816, 18'sd130559);

        // Size sweep: single cell, zero, oversize, strips, small grids
        run_phase(1, 1, 1'b1, 1'b0);
        run_phase(0, 0, 1'b1, 1'b0);
        run_phase(1023, 1023, 1'b1, 1'b0);
        run_phase(512, 1, 1'b0, 1'b0);
        run_phase(1, 512, 1'b1, 1'b0);
        run_phase(2, 2, 1'b1, 1'b1);
        run_phase(3, 7, 1'b1, 1'b0);
        run_phase(0, 600, 1'b1, 1'b0);
        run_phase(16, 9, 1'b1, 1'b0);
        for (k = 0; k < 4; k++) begin
            if ($urandom_range(0, 3) == 0)
                run_phase($urandom_range(0, 1023), $urandom_range(0, 1023), 1'b1, 1'b0);
            else
                run_phase($urandom_range(1, 40), $urandom_range(1, 40), 1'b1, 1'b0);
        end
        run_phase(512, 512, 1'b0, 1'b0);

        // Drain and settle, then give the verdict
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/bhs_pkg.sv
rtl/bhs_front.sv
rtl/bhs_queue.sv
rtl/bhs_back.sv
rtl/bilinear_height_sampler_core.sv
tb/sv/height_sample_monitor.sv
tb/sv/tb.sv
